>>> sv/ote_pkg.sv
`timescale 1ns / 1ps

package ote_pkg;

    // capacities
    localparam int DOC_CAP  = 256;
    localparam int TEXT_CAP = 64;
    localparam int HIST_CAP = 64;

    localparam int DOC_AW  = $clog2(DOC_CAP);
    localparam int TEXT_AW = $clog2(TEXT_CAP);
    localparam int HIST_AW = $clog2(HIST_CAP);

    // field widths
    localparam int FUNC_W  = 2;
    localparam int KIND_W  = 2;
    localparam int LEN_W   = 9;
    localparam int SITE_W  = 16;
    localparam int REV_W   = 31;
    localparam int CNT_W   = 32;
    localparam int IDX_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 2;
    localparam int POS_SW  = 12;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register map
    localparam logic [PADDR_W-1:0] ADDR_LOCAL_SITE = 3'd0;

    // item functions
    localparam logic [FUNC_W-1:0] FN_LOCAL  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOTE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_STAGE  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd3;

    // op kinds
    localparam logic [KIND_W-1:0] KIND_NOP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOEFF = 2'd1;
    localparam logic [STAT_W-1:0] ST_REJ   = 2'd2;

    // one entry of the op history
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic [SITE_W-1:0] site;
    } hist_t;

    localparam int HIST_W = $bits(hist_t);

endpackage

>>> sv/ote_if.sv
`timescale 1ns / 1ps

interface ote_req_if;
    import ote_pkg::*;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [KIND_W-1:0]   op_kind;
    logic [LEN_W-1:0]    position;
    logic [LEN_W-1:0]    length;
    logic [SITE_W-1:0]   origin_site;
    logic [REV_W-1:0]    base_revision;
    logic [IDX_W-1:0]    byte_index;
    logic [BYTE_W-1:0]   payload_byte;

    modport source (output valid, func, op_kind, position, length, origin_site,
                    base_revision, byte_index, payload_byte, input ready);
    modport sink (input valid, func, op_kind, position, length, origin_site,
                  base_revision, byte_index, payload_byte, output ready);
endinterface

interface ote_rsp_if;
    import ote_pkg::*;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [REV_W-1:0]    revision;
    logic [LEN_W-1:0]    doc_length;
    logic [BYTE_W-1:0]   read_byte;

    modport source (output valid, status, revision, doc_length, read_byte, input ready);
    modport sink (input valid, status, revision, doc_length, read_byte, output ready);
endinterface

>>> sv/ote_ram.sv
`timescale 1ns / 1ps

module ote_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/ote_xform.sv
`timescale 1ns / 1ps

module ote_xform (
    input  logic [ote_pkg::KIND_W-1:0]        kind,
    input  logic signed [ote_pkg::POS_SW-1:0] pos,
    input  logic signed [ote_pkg::POS_SW-1:0] len,
    input  logic [ote_pkg::SITE_W-1:0]        site,
    input  ote_pkg::hist_t                    hent,
    output logic signed [ote_pkg::POS_SW-1:0] pos_out,
    output logic signed [ote_pkg::POS_SW-1:0] len_out
);
    import ote_pkg::*;

    logic signed [POS_SW-1:0] hp;
    logic signed [POS_SW-1:0] hl;
    logic signed [POS_SW-1:0] hend;
    logic signed [POS_SW-1:0] over;
    logic signed [POS_SW-1:0] p;
    logic signed [POS_SW-1:0] l;
    logic                     clamp;

    // move the op past one earlier history entry
    always_comb
    begin
        hp    = signed'({{(POS_SW-LEN_W){1'b0}}, hent.pos});
        hl    = signed'({{(POS_SW-LEN_W){1'b0}}, hent.len});
        hend  = hp + hl;
        over  = '0;
        p     = pos;
        l     = len;
        clamp = 1'b1;
        if (hent.kind == KIND_INS)
        begin
            if (hp < p || (hp == p && hent.site < site))
            begin
                p = p + hl;
            end
        end
        else if (hent.kind == KIND_DEL)
        begin
            if (hend <= p)
            begin
                p = p - hl;
            end
            else if (hp <= p)
            begin
                if (kind == KIND_DEL)
                begin
                    over = hend - p;
                    l = (over < l) ? (l - over) : '0;
                end
                p = hp;
            end
            else if (kind == KIND_DEL && hp < p + l)
            begin
                over = (p + l) - hp;
                l = (over < l) ? (l - over) : '0;
            end
        end
        else
        begin
            clamp = 1'b0;
        end

        // clamp to the document range
        if (clamp)
        begin
            if (l < 0)
            begin
                l = '0;
            end
            if (p < 0)
            begin
                p = '0;
            end
            if (p > POS_SW'(DOC_CAP))
            begin
                p = POS_SW'(DOC_CAP);
            end
        end
        pos_out = p;
        len_out = l;
    end

endmodule

>>> sv/ot_text_buffer_engine_top.sv
`timescale 1ns / 1ps
// Text buffer engine with insert/delete operational transform.
// Input words arrive on req (valid/ready): local op, remote op, stage one
// insert byte, or read one document byte. Each word gives one result word on
// rsp (valid/ready) with status, revision, document length and read byte.
// The block takes one word at a time; req.ready is high only while idle.
// Steps per word, from accept to result loaded:
//   stage, no-op, reject at accept: result; read in range: read wait, result
//   local insert: check (result if it fails), move bytes, copy text, commit
//   local delete: check (result if it fails), move bytes, commit
//   remote op: walk history entries behind (up to 64), then as local op
// The byte move and insert copy run through the document memory port, with a
// read state then a write state per byte; the history walk reuses one
// transform unit per entry.
// A finished result sits in the rsp register; a new word can be accepted
// while it waits, and the next result holds until rsp.ready takes the first.
// Reset clears length, counters, staged-byte valid bits and local_site; the
// document is empty after reset. local_site is written over the APB port.

module ot_text_buffer_engine_top (
    input  logic                          clk,
    input  logic                          rst_n,
    ote_req_if.sink                       req,
    ote_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ote_pkg::PADDR_W-1:0]   paddr,
    input  logic [ote_pkg::PDATA_W-1:0]   pwdata,
    output logic [ote_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import ote_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_HRD, S_HXF, S_CHECK, S_INS_RD, S_INS_WR, S_CPY_RD, S_CPY_WR,
        S_DEL_RD, S_DEL_WR, S_RD_WAIT, S_COMMIT, S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [SITE_W-1:0]        local_site_reg, local_site_next;
    logic [LEN_W-1:0]         doc_len_reg, doc_len_next;
    logic [CNT_W-1:0]         rev_reg, rev_next;
    logic [CNT_W-1:0]         applied_reg, applied_next;
    logic [TEXT_CAP-1:0]      stg_vld_reg, stg_vld_next;

    logic                     remote_reg, remote_next;
    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic signed [POS_SW-1:0] pos_reg, pos_next;
    logic signed [POS_SW-1:0] len_reg, len_next;
    logic [SITE_W-1:0]        site_reg, site_next;
    logic [HIST_AW-1:0]       hptr_reg, hptr_next;
    logic [HIST_AW:0]         hcnt_reg, hcnt_next;
    logic [LEN_W-1:0]         mv_cnt_reg, mv_cnt_next;
    logic [DOC_AW-1:0]        src_reg, src_next;
    logic [TEXT_AW:0]         j_reg, j_next;
    logic [STAT_W-1:0]        status_reg, status_next;
    logic [BYTE_W-1:0]        rd_reg, rd_next;

    logic                     out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]        out_status_reg, out_status_next;
    logic [REV_W-1:0]         out_rev_reg, out_rev_next;
    logic [LEN_W-1:0]         out_len_reg, out_len_next;
    logic [BYTE_W-1:0]        out_byte_reg, out_byte_next;

    // memory ports
    logic                     doc_we;
    logic [DOC_AW-1:0]        doc_waddr, doc_raddr;
    logic [BYTE_W-1:0]        doc_wdata, doc_rdata;
    logic                     stg_we;
    logic [TEXT_AW-1:0]       stg_waddr, stg_raddr;
    logic [BYTE_W-1:0]        stg_wdata, stg_rdata;
    logic                     hist_we;
    logic [HIST_AW-1:0]       hist_waddr, hist_raddr;
    hist_t                    hist_wdata, hist_rdata;

    logic signed [POS_SW-1:0] xf_pos, xf_len;
    logic signed [POS_SW-1:0] dl_s;
    logic [CNT_W-1:0]         behind;
    logic                     base_gt;
    logic                     is_op;
    logic                     ins_rej, del_rej;

    ote_ram #(.WIDTH(BYTE_W), .DEPTH(DOC_CAP)) u_doc (
        .clk   (clk),
        .we    (doc_we),
        .waddr (doc_waddr),
        .wdata (doc_wdata),
        .raddr (doc_raddr),
        .rdata (doc_rdata)
    );

    ote_ram #(.WIDTH(BYTE_W), .DEPTH(TEXT_CAP)) u_stg (
        .clk   (clk),
        .we    (stg_we),
        .waddr (stg_waddr),
        .wdata (stg_wdata),
        .raddr (stg_raddr),
        .rdata (stg_rdata)
    );

    ote_ram #(.WIDTH(HIST_W), .DEPTH(HIST_CAP)) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // shared transform unit, one history entry per use
    ote_xform u_xform (
        .kind    (kind_reg),
        .pos     (pos_reg),
        .len     (len_reg),
        .site    (site_reg),
        .hent    (hist_rdata),
        .pos_out (xf_pos),
        .len_out (xf_len)
    );

    // handshake and config read
    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.revision   = out_rev_reg;
    assign rsp.doc_length = out_len_reg;
    assign rsp.read_byte  = out_byte_reg;
    assign pready         = 1'b1;
    assign prdata         = (paddr == ADDR_LOCAL_SITE) ?
                            {{(PDATA_W-SITE_W){1'b0}}, local_site_reg} : '0;

    // shared checks
    assign dl_s    = signed'({{(POS_SW-LEN_W){1'b0}}, doc_len_reg});
    assign behind  = rev_reg - {1'b0, req.base_revision};
    assign base_gt = {1'b0, req.base_revision} > rev_reg;
    assign is_op   = (req.op_kind == KIND_INS) || (req.op_kind == KIND_DEL);
    assign ins_rej = (pos_reg > dl_s) || (len_reg == '0) ||
                     (len_reg > POS_SW'(TEXT_CAP)) || (dl_s + len_reg > POS_SW'(DOC_CAP));
    assign del_rej = (len_reg == '0) || (pos_reg + len_reg > dl_s);

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        local_site_next = local_site_reg;
        doc_len_next    = doc_len_reg;
        rev_next        = rev_reg;
        applied_next    = applied_reg;
        stg_vld_next    = stg_vld_reg;
        remote_next     = remote_reg;
        kind_next       = kind_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        site_next       = site_reg;
        hptr_next       = hptr_reg;
        hcnt_next       = hcnt_reg;
        mv_cnt_next     = mv_cnt_reg;
        src_next        = src_reg;
        j_next          = j_reg;
        status_next     = status_reg;
        rd_next         = rd_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_rev_next    = out_rev_reg;
        out_len_next    = out_len_reg;
        out_byte_next   = out_byte_reg;
        doc_we          = 1'b0;
        doc_waddr       = '0;
        doc_wdata       = '0;
        doc_raddr       = '0;
        stg_we          = 1'b0;
        stg_waddr       = req.byte_index[TEXT_AW-1:0];
        stg_wdata       = req.payload_byte;
        stg_raddr       = j_reg[TEXT_AW-1:0];
        hist_we         = 1'b0;
        hist_waddr      = applied_reg[HIST_AW-1:0];
        hist_wdata      = '{kind: kind_reg, pos: pos_reg[LEN_W-1:0],
                            len: len_reg[LEN_W-1:0], site: site_reg};
        hist_raddr      = hptr_reg;

        // config write
        if (psel && penable && pwrite && paddr == ADDR_LOCAL_SITE)
        begin
            local_site_next = pwdata[SITE_W-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next   = req.op_kind;
                    pos_next    = signed'({{(POS_SW-LEN_W){1'b0}}, req.position});
                    len_next    = signed'({{(POS_SW-LEN_W){1'b0}}, req.length});
                    remote_next = (req.func == FN_REMOTE);
                    site_next   = (req.func == FN_LOCAL) ? local_site_reg : req.origin_site;
                    rd_next     = '0;
                    status_next = ST_DONE;
                    state_next  = S_FIN;
                    unique case (req.func)
                        FN_LOCAL:
                        begin
                            if (is_op)
                            begin
                                state_next = S_CHECK;
                            end
                            else
                            begin
                                status_next = ST_NOEFF;
                            end
                        end
                        FN_REMOTE:
                        begin
                            if (!is_op)
                            begin
                                status_next = ST_NOEFF;
                            end
                            else if (base_gt || behind > CNT_W'(HIST_CAP) ||
                                     behind > applied_reg ||
                                     (req.op_kind == KIND_INS &&
                                      req.length > LEN_W'(TEXT_CAP)))
                            begin
                                status_next = ST_REJ;
                            end
                            else
                            begin
                                hcnt_next  = behind[HIST_AW:0];
                                hptr_next  = applied_reg[HIST_AW-1:0] - behind[HIST_AW-1:0];
                                state_next = S_HRD;
                            end
                        end
                        FN_STAGE:
                        begin
                            if (req.byte_index < IDX_W'(TEXT_CAP))
                            begin
                                stg_we = 1'b1;
                                stg_vld_next[req.byte_index[TEXT_AW-1:0]] = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_REJ;
                            end
                        end
                        FN_READ:
                        begin
                            if ({1'b0, req.byte_index} < doc_len_reg)
                            begin
                                doc_raddr  = req.byte_index[DOC_AW-1:0];
                                state_next = S_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // history walk
            S_HRD:
            begin
                if (hcnt_reg == '0)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_HXF;
                end
            end
            S_HXF:
            begin
                pos_next   = xf_pos;
                len_next   = xf_len;
                hptr_next  = hptr_reg + 1'b1;
                hcnt_next  = hcnt_reg - 1'b1;
                state_next = S_HRD;
            end

            // apply checks
            S_CHECK:
            begin
                if (remote_reg && kind_reg == KIND_DEL && len_reg <= 0)
                begin
                    rev_next    = rev_reg + 1'b1;
                    status_next = ST_NOEFF;
                    state_next  = S_FIN;
                end
                else if (kind_reg == KIND_INS)
                begin
                    if (ins_rej)
                    begin
                        status_next = ST_REJ;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        mv_cnt_next = doc_len_reg - pos_reg[LEN_W-1:0];
                        src_next    = doc_len_reg[DOC_AW-1:0] - 1'b1;
                        j_next      = '0;
                        state_next  = S_INS_RD;
                    end
                end
                else
                begin
                    if (del_rej)
                    begin
                        status_next = ST_REJ;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        mv_cnt_next = doc_len_reg - pos_reg[LEN_W-1:0] - len_reg[LEN_W-1:0];
                        src_next    = pos_reg[DOC_AW-1:0] + len_reg[DOC_AW-1:0];
                        state_next  = S_DEL_RD;
                    end
                end
            end

            // open a gap, top byte first
            S_INS_RD:
            begin
                if (mv_cnt_reg == '0)
                begin
                    state_next = S_CPY_RD;
                end
                else
                begin
                    doc_raddr  = src_reg;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                doc_we      = 1'b1;
                doc_waddr   = src_reg + len_reg[DOC_AW-1:0];
                doc_wdata   = doc_rdata;
                src_next    = src_reg - 1'b1;
                mv_cnt_next = mv_cnt_reg - 1'b1;
                state_next  = S_INS_RD;
            end

            // copy staged text into the gap
            S_CPY_RD:
            begin
                if (j_reg == len_reg[TEXT_AW:0])
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    state_next = S_CPY_WR;
                end
            end
            S_CPY_WR:
            begin
                doc_we     = 1'b1;
                doc_waddr  = pos_reg[DOC_AW-1:0] + DOC_AW'(j_reg);
                doc_wdata  = stg_vld_reg[j_reg[TEXT_AW-1:0]] ? stg_rdata : '0;
                j_next     = j_reg + 1'b1;
                state_next = S_CPY_RD;
            end

            // close the gap, bottom byte first
            S_DEL_RD:
            begin
                if (mv_cnt_reg == '0)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    doc_raddr  = src_reg;
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR:
            begin
                doc_we      = 1'b1;
                doc_waddr   = src_reg - len_reg[DOC_AW-1:0];
                doc_wdata   = doc_rdata;
                src_next    = src_reg + 1'b1;
                mv_cnt_next = mv_cnt_reg - 1'b1;
                state_next  = S_DEL_RD;
            end

            S_RD_WAIT:
            begin
                rd_next    = doc_rdata;
                state_next = S_FIN;
            end

            // record the op
            S_COMMIT:
            begin
                hist_we      = 1'b1;
                doc_len_next = (kind_reg == KIND_INS) ?
                               doc_len_reg + len_reg[LEN_W-1:0] :
                               doc_len_reg - len_reg[LEN_W-1:0];
                applied_next = applied_reg + 1'b1;
                rev_next     = rev_reg + 1'b1;
                status_next  = ST_DONE;
                state_next   = S_FIN;
            end

            // hand the result to the output register
            S_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_rev_next    = rev_reg[REV_W-1:0];
                    out_len_next    = doc_len_reg;
                    out_byte_next   = rd_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            local_site_reg <= '0;
            doc_len_reg    <= '0;
            rev_reg        <= '0;
            applied_reg    <= '0;
            stg_vld_reg    <= '0;
            remote_reg     <= 1'b0;
            kind_reg       <= KIND_NOP;
            pos_reg        <= '0;
            len_reg        <= '0;
            site_reg       <= '0;
            hptr_reg       <= '0;
            hcnt_reg       <= '0;
            mv_cnt_reg     <= '0;
            src_reg        <= '0;
            j_reg          <= '0;
            status_reg     <= ST_DONE;
            rd_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_DONE;
            out_rev_reg    <= '0;
            out_len_reg    <= '0;
            out_byte_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            local_site_reg <= local_site_next;
            doc_len_reg    <= doc_len_next;
            rev_reg        <= rev_next;
            applied_reg    <= applied_next;
            stg_vld_reg    <= stg_vld_next;
            remote_reg     <= remote_next;
            kind_reg       <= kind_next;
            pos_reg        <= pos_next;
            len_reg        <= len_next;
            site_reg       <= site_next;
            hptr_reg       <= hptr_next;
            hcnt_reg       <= hcnt_next;
            mv_cnt_reg     <= mv_cnt_next;
            src_reg        <= src_next;
            j_reg          <= j_next;
            status_reg     <= status_next;
            rd_reg         <= rd_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_rev_reg    <= out_rev_next;
            out_len_reg    <= out_len_next;
            out_byte_reg   <= out_byte_next;
        end
    end

endmodule
